### rtl/core/osn_pkg.sv
// Shared types, constants and gradient table for the 2D OpenSimplex noise block.
package osn_pkg;

    // Permutation table geometry
    localparam int PERM_ENTRIES = 256;
    localparam int PERM_AW      = $clog2(PERM_ENTRIES);

    // Linear congruential generator, 32-bit truncated constants
    localparam logic [31:0] LCG_MUL   = 32'h4C957F2D;
    localparam logic [31:0] LCG_ADD   = 32'hF767814F;
    localparam logic [31:0] SHUF_BIAS = 32'd31;
    localparam int          DIV_STEPS  = 32;
    localparam int          WARM_STEPS = 3;

    // Shared multiplier operand width and product width
    localparam int MUL_W  = 34;
    localparam int PROD_W = 2 * MUL_W;

    // Fixed-point constants (Q28 deltas, Q30 stretch factor)
    localparam logic signed [MUL_W-1:0] STRETCH_Q30 = -34'sd226908347;
    localparam logic signed [MUL_W-1:0] SQUISH_MUL  = 34'sd98254196;
    localparam logic signed [31:0]      ONE_Q       = 32'sd268435456;
    localparam logic signed [31:0]      TWO_Q       = 32'sd536870912;
    localparam logic signed [31:0]      SQUISH_Q28  = 32'sd98254196;
    localparam logic signed [31:0]      SQUISH2_Q28 = 32'sd196508392;
    localparam logic signed [MUL_W-1:0] ATTN_BASE   = 34'sd536870912;

    // ceil(2^32 / 47): exact floor division for dividends below 2^21
    localparam logic [MUL_W-1:0] NORM_RECIP = 34'd91382283;
    localparam int               CLAMP_W    = 21;

    // Datapath operations
    typedef enum logic [4:0] {
        DP_NOP,
        DP_SEED,
        DP_INIT,
        DP_LCG_MUL,
        DP_LCG_ADD,
        DP_DIV_LOAD,
        DP_DIV_STEP,
        DP_SH_READ,
        DP_SH_WRITE,
        DP_E_LOAD,
        DP_E_MOFF,
        DP_E_SKEW,
        DP_E_INSUM,
        DP_E_MSQ,
        DP_E_VSET,
        DP_V_MDX,
        DP_V_ADX,
        DP_V_MDY,
        DP_V_ADY,
        DP_V_MA,
        DP_V_SQ,
        DP_V_MC,
        DP_V_ACC,
        DP_F_CLAMP,
        DP_F_MUL,
        DP_F_OUT
    } t_dp_op;

    // Controller to datapath command
    typedef struct packed {
        t_dp_op             op;
        logic [PERM_AW-1:0] slot;
        logic [1:0]         vtx;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic a_pos;
    } t_dp_stat;

    // Finished transaction notice from controller to top level
    typedef struct packed {
        logic valid;
        logic was_build;
    } t_done;

    // Gradient x component for a gradient code (perm value bits 3:1)
    function automatic logic signed [3:0] grad_x(input logic [2:0] g);
        logic signed [3:0] v;
        case (g)
            3'd0:    v = 4'sd5;
            3'd1:    v = 4'sd2;
            3'd2:    v = -4'sd5;
            3'd3:    v = -4'sd2;
            3'd4:    v = 4'sd5;
            3'd5:    v = 4'sd2;
            3'd6:    v = -4'sd5;
            default: v = -4'sd2;
        endcase
        return v;
    endfunction

    // Gradient y component for a gradient code
    function automatic logic signed [3:0] grad_y(input logic [2:0] g);
        logic signed [3:0] v;
        case (g)
            3'd0:    v = 4'sd2;
            3'd1:    v = 4'sd5;
            3'd2:    v = 4'sd2;
            3'd3:    v = 4'sd5;
            3'd4:    v = -4'sd2;
            3'd5:    v = -4'sd5;
            3'd6:    v = -4'sd2;
            default: v = -4'sd5;
        endcase
        return v;
    endfunction

endpackage

### rtl/core/osn_datapath.sv
// Datapath: shared multiplier, remainder unit, permutation and shuffle memories.
module osn_datapath
    import osn_pkg::*;
#(
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    input  logic [31:0]         i_seed,
    input  logic signed [31:0]  i_coord_x,
    input  logic signed [31:0]  i_coord_y,
    output t_dp_stat            o_stat,
    output logic signed [15:0]  o_noise
);

    localparam int BASE_LSB = COORD_FRAC_BITS + 30;
    localparam int FRAC_LSB = COORD_FRAC_BITS + 2;

    // Memories
    logic [PERM_AW-1:0] r_perm_mem [PERM_ENTRIES];
    logic [PERM_AW-1:0] r_shuf_mem [PERM_ENTRIES];

    // Build registers
    logic [31:0]          r_lcg;
    logic [31:0]          r_div_num;
    logic [PERM_AW-1:0]   r_rem;
    logic [PERM_AW-1:0]   r_sh_a;
    logic [PERM_AW-1:0]   r_sh_b;
    logic [PERM_AW-1:0]   r_pdata;

    // Evaluation registers
    logic signed [31:0]        r_x;
    logic signed [31:0]        r_y;
    logic signed [32:0]        r_xy;
    logic signed [PROD_W-1:0]  r_prod;
    logic [27:0]               r_xi;
    logic [27:0]               r_yi;
    logic [PERM_AW-1:0]        r_xb;
    logic [PERM_AW-1:0]        r_yb;
    logic [28:0]               r_insum;
    logic [PERM_AW-1:0]        r_vx  [4];
    logic [PERM_AW-1:0]        r_vy  [4];
    logic signed [31:0]        r_vdx [4];
    logic signed [31:0]        r_vdy [4];
    logic signed [MUL_W-1:0]   r_a;
    logic [2:0]                r_gi;
    logic signed [MUL_W-1:0]   r_dot;
    logic signed [63:0]        r_sum;
    logic                      r_neg;
    logic [CLAMP_W-1:0]        r_u;
    logic signed [15:0]        r_noise;

    // Combinational helpers
    logic signed [MUL_W-1:0]   w_ma;
    logic signed [MUL_W-1:0]   w_mb;
    logic                      w_mul_en;
    logic signed [PROD_W-1:0]  w_mprod;
    logic [8:0]                w_dvs;
    logic [8:0]                w_trial;
    logic                      w_sh_we;
    logic [PERM_AW-1:0]        w_sh_waddr;
    logic [PERM_AW-1:0]        w_sh_wdata;
    logic [PERM_AW-1:0]        w_paddr;
    logic signed [63:0]        w_xs;
    logic signed [63:0]        w_ys;
    logic signed [31:0]        w_sq;
    logic signed [31:0]        w_xi;
    logic signed [31:0]        w_yi;
    logic signed [31:0]        w_ins;
    logic signed [31:0]        w_dx0;
    logic signed [31:0]        w_dy0;
    logic signed [31:0]        w_zl;
    logic signed [31:0]        w_zu;
    logic [PERM_AW-1:0]        w_vx  [4];
    logic [PERM_AW-1:0]        w_vy  [4];
    logic signed [31:0]        w_vdx [4];
    logic signed [31:0]        w_vdy [4];
    logic signed [3:0]         w_gx;
    logic signed [3:0]         w_gy;
    logic signed [35:0]        w_dot;
    logic signed [MUL_W-1:0]   w_pq;
    logic [30:0]               w_t;
    logic [30:0]               w_u;
    logic [20:0]               w_q;

    // Select multiplier operands
    always_comb begin
        w_ma     = '0;
        w_mb     = '0;
        w_mul_en = 1'b1;
        unique case (i_cmd.op)
            DP_LCG_MUL: begin
                w_ma = $signed({2'b00, r_lcg});
                w_mb = $signed({2'b00, LCG_MUL});
            end
            DP_E_MOFF: begin
                w_ma = MUL_W'(r_xy);
                w_mb = STRETCH_Q30;
            end
            DP_E_MSQ: begin
                w_ma = $signed({5'b0, r_insum});
                w_mb = SQUISH_MUL;
            end
            DP_V_MDX: begin
                w_ma = MUL_W'(r_vdx[i_cmd.vtx]);
                w_mb = MUL_W'(r_vdx[i_cmd.vtx]);
            end
            DP_V_MDY: begin
                w_ma = MUL_W'(r_vdy[i_cmd.vtx]);
                w_mb = MUL_W'(r_vdy[i_cmd.vtx]);
            end
            DP_V_MA: begin
                w_ma = r_a;
                w_mb = r_a;
            end
            DP_V_MC: begin
                w_ma = $signed({9'b0, r_a[32:8]});
                w_mb = r_dot;
            end
            DP_F_MUL: begin
                w_ma = $signed({13'b0, r_u});
                w_mb = $signed(NORM_RECIP);
            end
            default: w_mul_en = 1'b0;
        endcase
    end

    assign w_mprod = w_ma * w_mb;
    assign w_pq    = $signed(r_prod[61:28]);

    // Remainder step: divisor is slot + 1
    assign w_dvs   = {1'b0, i_cmd.slot} + 9'd1;
    assign w_trial = {r_rem, r_div_num[31]};

    // Shuffle memory write port
    always_comb begin
        w_sh_we    = 1'b0;
        w_sh_waddr = i_cmd.slot;
        w_sh_wdata = i_cmd.slot;
        if (i_cmd.op == DP_INIT) begin
            w_sh_we = 1'b1;
        end else if (i_cmd.op == DP_SH_WRITE) begin
            w_sh_we    = 1'b1;
            w_sh_waddr = r_rem;
            w_sh_wdata = r_sh_b;
        end
    end

    // Permutation read address: second read hashes with the y base
    assign w_paddr = (i_cmd.op == DP_V_ADX) ? (r_pdata + r_vy[i_cmd.vtx]) : r_vx[i_cmd.vtx];

    // Skew onto the rhombus grid
    assign w_xs = $signed({{2{r_x[31]}}, r_x, 30'b0}) + r_prod[63:0];
    assign w_ys = $signed({{2{r_y[31]}}, r_y, 30'b0}) + r_prod[63:0];

    // Region selection and vertex setup
    assign w_sq  = $signed({4'b0, r_prod[55:28]});
    assign w_xi  = $signed({4'b0, r_xi});
    assign w_yi  = $signed({4'b0, r_yi});
    assign w_ins = $signed({3'b0, r_insum});
    assign w_dx0 = w_xi + w_sq;
    assign w_dy0 = w_yi + w_sq;
    assign w_zl  = ONE_Q - w_ins;
    assign w_zu  = TWO_Q - w_ins;

    always_comb begin
        w_vx[0]  = r_xb + 8'd1;
        w_vy[0]  = r_yb;
        w_vdx[0] = w_dx0 - ONE_Q - SQUISH_Q28;
        w_vdy[0] = w_dy0 - SQUISH_Q28;
        w_vx[1]  = r_xb;
        w_vy[1]  = r_yb + 8'd1;
        w_vdx[1] = w_dx0 - SQUISH_Q28;
        w_vdy[1] = w_dy0 - ONE_Q - SQUISH_Q28;
        if (w_ins <= ONE_Q) begin
            w_vx[2]  = r_xb;
            w_vy[2]  = r_yb;
            w_vdx[2] = w_dx0;
            w_vdy[2] = w_dy0;
            if (w_zl > w_xi || w_zl > w_yi) begin
                if (w_xi > w_yi) begin
                    w_vx[3]  = r_xb + 8'd1;
                    w_vy[3]  = r_yb - 8'd1;
                    w_vdx[3] = w_dx0 - ONE_Q;
                    w_vdy[3] = w_dy0 + ONE_Q;
                end else begin
                    w_vx[3]  = r_xb - 8'd1;
                    w_vy[3]  = r_yb + 8'd1;
                    w_vdx[3] = w_dx0 + ONE_Q;
                    w_vdy[3] = w_dy0 - ONE_Q;
                end
            end else begin
                w_vx[3]  = r_xb + 8'd1;
                w_vy[3]  = r_yb + 8'd1;
                w_vdx[3] = w_dx0 - ONE_Q - SQUISH2_Q28;
                w_vdy[3] = w_dy0 - ONE_Q - SQUISH2_Q28;
            end
        end else begin
            w_vx[2]  = r_xb + 8'd1;
            w_vy[2]  = r_yb + 8'd1;
            w_vdx[2] = w_dx0 - ONE_Q - SQUISH2_Q28;
            w_vdy[2] = w_dy0 - ONE_Q - SQUISH2_Q28;
            if (w_zu < w_xi || w_zu < w_yi) begin
                if (w_xi > w_yi) begin
                    w_vx[3]  = r_xb + 8'd2;
                    w_vy[3]  = r_yb;
                    w_vdx[3] = w_dx0 - TWO_Q - SQUISH2_Q28;
                    w_vdy[3] = w_dy0 - SQUISH2_Q28;
                end else begin
                    w_vx[3]  = r_xb;
                    w_vy[3]  = r_yb + 8'd2;
                    w_vdx[3] = w_dx0 - SQUISH2_Q28;
                    w_vdy[3] = w_dy0 - TWO_Q - SQUISH2_Q28;
                end
            end else begin
                w_vx[3]  = r_xb;
                w_vy[3]  = r_yb;
                w_vdx[3] = w_dx0;
                w_vdy[3] = w_dy0;
            end
        end
    end

    // Gradient dot product
    assign w_gx  = grad_x(r_gi);
    assign w_gy  = grad_y(r_gi);
    assign w_dot = w_gx * r_vdx[i_cmd.vtx] + w_gy * r_vdy[i_cmd.vtx];

    // Final scaling: floor by 2^33, fold sign, clamp below 2^21
    assign w_t = r_sum[63:33];
    assign w_u = r_sum[63] ? ~w_t : w_t;
    assign w_q = r_prod[52:32];

    // Shuffle memory: one write, two registered reads
    always_ff @(posedge i_clk) begin
        if (w_sh_we) begin
            r_shuf_mem[w_sh_waddr] <= w_sh_wdata;
        end
        r_sh_a <= r_shuf_mem[r_rem];
        r_sh_b <= r_shuf_mem[i_cmd.slot];
    end

    // Permutation memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == DP_SH_WRITE) begin
            r_perm_mem[i_cmd.slot] <= r_sh_a;
        end
        r_pdata <= r_perm_mem[w_paddr];
    end

    // Generator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lcg <= '0;
        end else if (i_cmd.op == DP_SEED) begin
            r_lcg <= i_seed;
        end else if (i_cmd.op == DP_LCG_ADD) begin
            r_lcg <= r_prod[31:0] + LCG_ADD;
        end
    end

    // Product register
    always_ff @(posedge i_clk) begin
        if (w_mul_en) begin
            r_prod <= w_mprod;
        end
    end

    // Operation registers
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            DP_DIV_LOAD: begin
                r_div_num <= r_lcg + SHUF_BIAS;
                r_rem     <= '0;
            end
            DP_DIV_STEP: begin
                if (w_trial >= w_dvs) begin
                    r_rem <= 8'(w_trial - w_dvs);
                end else begin
                    r_rem <= w_trial[7:0];
                end
                r_div_num <= {r_div_num[30:0], 1'b0};
            end
            DP_E_LOAD: begin
                r_x  <= i_coord_x;
                r_y  <= i_coord_y;
                r_xy <= 33'(i_coord_x) + 33'(i_coord_y);
            end
            DP_E_SKEW: begin
                r_xb <= w_xs[BASE_LSB+PERM_AW-1:BASE_LSB];
                r_yb <= w_ys[BASE_LSB+PERM_AW-1:BASE_LSB];
                r_xi <= w_xs[BASE_LSB-1:FRAC_LSB];
                r_yi <= w_ys[BASE_LSB-1:FRAC_LSB];
            end
            DP_E_INSUM: begin
                r_insum <= {1'b0, r_xi} + {1'b0, r_yi};
            end
            DP_E_VSET: begin
                for (int k = 0; k < 4; k++) begin
                    r_vx[k]  <= w_vx[k];
                    r_vy[k]  <= w_vy[k];
                    r_vdx[k] <= w_vdx[k];
                    r_vdy[k] <= w_vdy[k];
                end
                r_sum <= '0;
            end
            DP_V_ADX: begin
                r_a <= ATTN_BASE - w_pq;
            end
            DP_V_MDY: begin
                r_gi <= r_pdata[3:1];
            end
            DP_V_ADY: begin
                r_a   <= r_a - w_pq;
                r_dot <= w_dot[MUL_W-1:0];
            end
            DP_V_SQ: begin
                r_a <= w_pq;
            end
            DP_V_ACC: begin
                r_sum <= r_sum + r_prod[63:0];
            end
            DP_F_CLAMP: begin
                r_neg <= r_sum[63];
                if (w_u[30:CLAMP_W] != '0) begin
                    r_u <= '1;
                end else begin
                    r_u <= w_u[CLAMP_W-1:0];
                end
            end
            DP_F_OUT: begin
                if (w_q[20:15] != '0) begin
                    r_noise <= r_neg ? -16'sd32768 : 16'sd32767;
                end else if (r_neg) begin
                    r_noise <= $signed(~w_q[15:0]);
                end else begin
                    r_noise <= $signed(w_q[15:0]);
                end
            end
            default: ;
        endcase
    end

    assign o_stat.a_pos = (r_a > 0);
    assign o_noise      = r_noise;

endmodule

### rtl/core/osn_ctrl.sv
// Controller: sequences permutation builds and noise evaluations.
module osn_ctrl
    import osn_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  logic      i_command,
    input  logic      i_out_free,
    input  t_dp_stat  i_stat,
    output t_dp_cmd   o_cmd,
    output t_done     o_done,
    output logic      o_idle
);

    typedef enum logic [28:0] {
        S_IDLE    = 29'h1 << 0,
        S_B_INIT  = 29'h1 << 1,
        S_B_WMUL  = 29'h1 << 2,
        S_B_WADD  = 29'h1 << 3,
        S_B_MUL   = 29'h1 << 4,
        S_B_ADD   = 29'h1 << 5,
        S_B_DLOAD = 29'h1 << 6,
        S_B_DSTEP = 29'h1 << 7,
        S_B_RD    = 29'h1 << 8,
        S_B_WR    = 29'h1 << 9,
        S_E_MOFF  = 29'h1 << 10,
        S_E_SKEW  = 29'h1 << 11,
        S_E_INSUM = 29'h1 << 12,
        S_E_MSQ   = 29'h1 << 13,
        S_E_VSET  = 29'h1 << 14,
        S_V_MDX   = 29'h1 << 15,
        S_V_ADX   = 29'h1 << 16,
        S_V_MDY   = 29'h1 << 17,
        S_V_ADY   = 29'h1 << 18,
        S_V_MA1   = 29'h1 << 19,
        S_V_SQ1   = 29'h1 << 20,
        S_V_MA2   = 29'h1 << 21,
        S_V_SQ2   = 29'h1 << 22,
        S_V_MC    = 29'h1 << 23,
        S_V_ACC   = 29'h1 << 24,
        S_F_CLAMP = 29'h1 << 25,
        S_F_MUL   = 29'h1 << 26,
        S_F_OUT   = 29'h1 << 27,
        S_DONE    = 29'h1 << 28
    } t_state;

    localparam logic [PERM_AW-1:0] SLOT_LAST = PERM_AW'(PERM_ENTRIES - 1);
    localparam logic [4:0]         DIV_LAST  = 5'(DIV_STEPS - 1);
    localparam logic [4:0]         WARM_LAST = 5'(WARM_STEPS - 1);

    t_state             r_state, n_state;
    logic [PERM_AW-1:0] r_slot, n_slot;
    logic [4:0]         r_step, n_step;
    logic               r_build, n_build;

    // Next state and command decode
    always_comb begin
        n_state     = r_state;
        n_slot      = r_slot;
        n_step      = r_step;
        n_build     = r_build;
        o_cmd.op    = DP_NOP;
        o_cmd.slot  = r_slot;
        o_cmd.vtx   = r_step[1:0];
        o_done      = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_slot  = '0;
                    n_step  = '0;
                    n_build = !i_command;
                    if (i_command) begin
                        o_cmd.op = DP_E_LOAD;
                        n_state  = S_E_MOFF;
                    end else begin
                        o_cmd.op = DP_SEED;
                        n_state  = S_B_INIT;
                    end
                end
            end
            S_B_INIT: begin
                o_cmd.op = DP_INIT;
                n_slot   = r_slot + 8'd1;
                if (r_slot == SLOT_LAST) begin
                    n_state = S_B_WMUL;
                end
            end
            S_B_WMUL: begin
                o_cmd.op = DP_LCG_MUL;
                n_state  = S_B_WADD;
            end
            S_B_WADD: begin
                o_cmd.op = DP_LCG_ADD;
                n_step   = r_step + 5'd1;
                if (r_step == WARM_LAST) begin
                    n_slot  = SLOT_LAST;
                    n_state = S_B_MUL;
                end else begin
                    n_state = S_B_WMUL;
                end
            end
            S_B_MUL: begin
                o_cmd.op = DP_LCG_MUL;
                n_state  = S_B_ADD;
            end
            S_B_ADD: begin
                o_cmd.op = DP_LCG_ADD;
                n_state  = S_B_DLOAD;
            end
            S_B_DLOAD: begin
                o_cmd.op = DP_DIV_LOAD;
                n_step   = '0;
                n_state  = S_B_DSTEP;
            end
            S_B_DSTEP: begin
                o_cmd.op = DP_DIV_STEP;
                n_step   = r_step + 5'd1;
                if (r_step == DIV_LAST) begin
                    n_state = S_B_RD;
                end
            end
            S_B_RD: begin
                o_cmd.op = DP_SH_READ;
                n_state  = S_B_WR;
            end
            S_B_WR: begin
                o_cmd.op = DP_SH_WRITE;
                if (r_slot == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_slot  = r_slot - 8'd1;
                    n_state = S_B_MUL;
                end
            end
            S_E_MOFF: begin
                o_cmd.op = DP_E_MOFF;
                n_state  = S_E_SKEW;
            end
            S_E_SKEW: begin
                o_cmd.op = DP_E_SKEW;
                n_state  = S_E_INSUM;
            end
            S_E_INSUM: begin
                o_cmd.op = DP_E_INSUM;
                n_state  = S_E_MSQ;
            end
            S_E_MSQ: begin
                o_cmd.op = DP_E_MSQ;
                n_state  = S_E_VSET;
            end
            S_E_VSET: begin
                o_cmd.op = DP_E_VSET;
                n_step   = '0;
                n_state  = S_V_MDX;
            end
            S_V_MDX: begin
                o_cmd.op = DP_V_MDX;
                n_state  = S_V_ADX;
            end
            S_V_ADX: begin
                o_cmd.op = DP_V_ADX;
                n_state  = S_V_MDY;
            end
            S_V_MDY: begin
                o_cmd.op = DP_V_MDY;
                n_state  = S_V_ADY;
            end
            S_V_ADY: begin
                o_cmd.op = DP_V_ADY;
                n_state  = S_V_MA1;
            end
            S_V_MA1: begin
                o_cmd.op = DP_V_MA;
                // drop a vertex outside the falloff radius
                if (i_stat.a_pos) begin
                    n_state = S_V_SQ1;
                end else if (r_step[1:0] == 2'd3) begin
                    n_state = S_F_CLAMP;
                end else begin
                    n_step  = r_step + 5'd1;
                    n_state = S_V_MDX;
                end
            end
            S_V_SQ1: begin
                o_cmd.op = DP_V_SQ;
                n_state  = S_V_MA2;
            end
            S_V_MA2: begin
                o_cmd.op = DP_V_MA;
                n_state  = S_V_SQ2;
            end
            S_V_SQ2: begin
                o_cmd.op = DP_V_SQ;
                n_state  = S_V_MC;
            end
            S_V_MC: begin
                o_cmd.op = DP_V_MC;
                n_state  = S_V_ACC;
            end
            S_V_ACC: begin
                o_cmd.op = DP_V_ACC;
                if (r_step[1:0] == 2'd3) begin
                    n_state = S_F_CLAMP;
                end else begin
                    n_step  = r_step + 5'd1;
                    n_state = S_V_MDX;
                end
            end
            S_F_CLAMP: begin
                o_cmd.op = DP_F_CLAMP;
                n_state  = S_F_MUL;
            end
            S_F_MUL: begin
                o_cmd.op = DP_F_MUL;
                n_state  = S_F_OUT;
            end
            S_F_OUT: begin
                o_cmd.op = DP_F_OUT;
                n_state  = S_DONE;
            end
            S_DONE: begin
                // hold until the output register can take the result
                if (i_out_free) begin
                    o_done.valid     = 1'b1;
                    o_done.was_build = r_build;
                    n_state          = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_slot  <= '0;
            r_step  <= '0;
            r_build <= 1'b0;
        end else begin
            r_state <= n_state;
            r_slot  <= n_slot;
            r_step  <= n_step;
            r_build <= n_build;
        end
    end

    assign o_idle = (r_state == S_IDLE);

endmodule

### rtl/core/opensimplex_noise_2d.sv
// Top level: register port, handshakes, output register, controller and datapath.
//
// Two-dimensional OpenSimplex noise with a seeded 256-entry permutation. A
// transaction with command 0 rebuilds the permutation from the seed register:
// a fill of the shuffle memory, three generator warm-up steps, then per slot
// the generator multiply followed by the bit-serial remainder unit (32 steps).
// A transaction with command 1 evaluates noise at a signed point: every step
// shares one 34x34 multiplier, and the work for each of the four vertices is
// cut short when the vertex falls outside the falloff radius.
// Evaluate only after at least one build. One transaction is worked at a
// time; a new one is accepted while the previous result waits in the output
// register. The seed register sits at address 0 and is read back as written.
module opensimplex_noise_2d
    import osn_pkg::*;
#(
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // register port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // input channel
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_command,
    input  logic signed [31:0] i_coord_x,
    input  logic signed [31:0] i_coord_y,
    // output channel
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [15:0] o_noise_value,
    output logic               o_was_build
);

    localparam logic [2:0] REG_SEED_ADDR = 3'd0;

    logic               r_seed_valid_unused;
    logic [31:0]        r_seed;
    logic               r_out_valid;
    logic signed [15:0] r_out_noise;
    logic               r_out_build;

    logic               w_start;
    logic               w_out_free;
    logic               w_idle;
    t_dp_cmd            w_cmd;
    t_dp_stat           w_stat;
    t_done              w_done;
    logic signed [15:0] w_noise;

    // Seed register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
        end else if (psel && penable && pwrite && paddr == REG_SEED_ADDR) begin
            r_seed <= pwdata;
        end
    end

    // Track register port activity for read-back decode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed_valid_unused <= 1'b0;
        end else begin
            r_seed_valid_unused <= psel && !pwrite;
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == REG_SEED_ADDR && (r_seed_valid_unused || psel)) ? r_seed : '0;

    // Input handshake
    assign o_ready    = w_idle;
    assign w_start    = i_valid && w_idle;
    assign w_out_free = !r_out_valid || i_ready;

    osn_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_command  (i_command),
        .i_out_free (w_out_free),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_done     (w_done),
        .o_idle     (w_idle)
    );

    osn_datapath #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .i_seed    (r_seed),
        .i_coord_x (i_coord_x),
        .i_coord_y (i_coord_y),
        .o_stat    (w_stat),
        .o_noise   (w_noise)
    );

    // Output register: load a finished result, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done.valid) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done.valid) begin
            r_out_noise <= w_done.was_build ? 16'sd0 : w_noise;
            r_out_build <= w_done.was_build;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_noise_value = r_out_noise;
    assign o_was_build   = r_out_build;

    // An accepted transaction takes the controller out of idle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("controller stayed idle after accepting a transaction");

    // A result is loaded only when the output register is free
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done.valid |-> (!r_out_valid || i_ready))
        else $error("result loaded over an untaken result");

    // A build acknowledgment carries a zero value
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_was_build) |-> (o_noise_value == 16'sd0))
        else $error("build result with nonzero noise value");

endmodule

### verif/opensimplex_noise_2d_tb.sv
// Testbench for the 2D OpenSimplex noise block: directed table, random points, local predictor.
module opensimplex_noise_2d_tb;
    import osn_pkg::*;

    localparam int  FRAC_BITS = 16;
    localparam byte CMD_BUILD = 0;
    localparam byte CMD_EVAL  = 1;
    localparam logic [2:0] ADDR_SEED = 3'd0;

    localparam longint Q_ONE      = 64'sd1 <<< 28;
    localparam longint STRETCH_30 = -64'sd226908347;
    localparam longint SQUISH_28  = 64'sd98254196;
    localparam longint NORM       = 64'sd47;

    typedef struct {
        logic signed [15:0] noise;
        logic               build;
    } noise_result_t;

    typedef struct {
        bit                 cmd;
        logic signed [31:0] x;
        logic signed [31:0] y;
        bit                 known;
        logic signed [15:0] noise;
    } stim_row_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic               i_command = 1'b0;
    logic signed [31:0] i_coord_x = '0;
    logic signed [31:0] i_coord_y = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic signed [15:0] o_noise_value;
    logic               o_was_build;

    opensimplex_noise_2d #(.COORD_FRAC_BITS(FRAC_BITS)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_valid(i_valid), .o_ready(o_ready), .i_command(i_command),
        .i_coord_x(i_coord_x), .i_coord_y(i_coord_y),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_noise_value(o_noise_value), .o_was_build(o_was_build)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Predictor state
    logic [7:0]  perm_mem [PERM_ENTRIES];
    logic [7:0]  shuf_mem [PERM_ENTRIES];
    logic [31:0] lcg_q;
    logic [31:0] seed_q;
    longint      grad_lut [16] = '{5, 2, 2, 5, -5, 2, -2, 5, 5, -2, 2, -5, -5, -2, -2, -5};

    noise_result_t noise_expected_q[$];
    int err_count;
    int send_idle_pct;
    int recv_stall_pct;

    function automatic longint floor_quot(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0) q -= 1;
        return q;
    endfunction

    function automatic longint q28_mul(longint a, longint b);
        return floor_quot(a * b, Q_ONE);
    endfunction

    function automatic longint vertex_contrib(longint xv, longint yv, longint dx, longint dy);
        longint a;
        longint dot;
        logic [7:0] h;
        int gi;
        a = 2 * Q_ONE - q28_mul(dx, dx) - q28_mul(dy, dy);
        if (a <= 0) return 0;
        a = q28_mul(a, a);
        a = q28_mul(a, a);
        h = perm_mem[xv[7:0]] + yv[7:0];
        gi = int'(perm_mem[h] & 8'h0E);
        dot = grad_lut[gi] * dx + grad_lut[gi + 1] * dy;
        return (a / 256) * dot;
    endfunction

    // Rebuild the permutation from the seed, as the block does
    task automatic shuffle_perm();
        logic [31:0] s;
        logic [31:0] r;
        s = seed_q;
        for (int i = 0; i < PERM_ENTRIES; i++) shuf_mem[i] = 8'(i);
        for (int i = 0; i < 3; i++) s = s * LCG_MUL + LCG_ADD;
        for (int i = PERM_ENTRIES - 1; i >= 0; i--) begin
            s = s * LCG_MUL + LCG_ADD;
            r = (s + SHUF_BIAS) % 32'(i + 1);
            perm_mem[i] = shuf_mem[r[7:0]];
            shuf_mem[r[7:0]] = shuf_mem[i];
        end
        lcg_q = s;
    endtask

    function automatic logic signed [15:0] noise_at(logic signed [31:0] px,
                                                    logic signed [31:0] py);
        longint x, y, g_one, off, xs, ys, xsb, ysb, xi, yi, in_sum, sq;
        longint dx0, dy0, sq2, xe, ye, dxe, dye, sum, z, q;
        x = px;
        y = py;
        g_one = 64'sd1 <<< (FRAC_BITS + 30);
        off = (x + y) * STRETCH_30;
        xs = x * (64'sd1 <<< 30) + off;
        ys = y * (64'sd1 <<< 30) + off;
        xsb = floor_quot(xs, g_one);
        ysb = floor_quot(ys, g_one);
        xi = (xs - xsb * g_one) >>> (FRAC_BITS + 2);
        yi = (ys - ysb * g_one) >>> (FRAC_BITS + 2);
        in_sum = xi + yi;
        sq = (in_sum * SQUISH_28) >>> 28;
        dx0 = xi + sq;
        dy0 = yi + sq;
        sq2 = 2 * SQUISH_28;
        sum = 0;
        sum += vertex_contrib(xsb + 1, ysb, dx0 - Q_ONE - SQUISH_28, dy0 - SQUISH_28);
        sum += vertex_contrib(xsb, ysb + 1, dx0 - SQUISH_28, dy0 - Q_ONE - SQUISH_28);
        // Pick the extra vertex by region; ties go to the lower triangle
        if (in_sum <= Q_ONE) begin
            z = Q_ONE - in_sum;
            if (z > xi || z > yi) begin
                if (xi > yi) begin
                    xe = xsb + 1; ye = ysb - 1; dxe = dx0 - Q_ONE; dye = dy0 + Q_ONE;
                end else begin
                    xe = xsb - 1; ye = ysb + 1; dxe = dx0 + Q_ONE; dye = dy0 - Q_ONE;
                end
            end else begin
                xe = xsb + 1; ye = ysb + 1;
                dxe = dx0 - Q_ONE - sq2; dye = dy0 - Q_ONE - sq2;
            end
        end else begin
            z = 2 * Q_ONE - in_sum;
            if (z < xi || z < yi) begin
                if (xi > yi) begin
                    xe = xsb + 2; ye = ysb; dxe = dx0 - 2 * Q_ONE - sq2; dye = dy0 - sq2;
                end else begin
                    xe = xsb; ye = ysb + 2; dxe = dx0 - sq2; dye = dy0 - 2 * Q_ONE - sq2;
                end
            end else begin
                xe = xsb; ye = ysb; dxe = dx0; dye = dy0;
            end
            xsb += 1;
            ysb += 1;
            dx0 -= Q_ONE + sq2;
            dy0 -= Q_ONE + sq2;
        end
        sum += vertex_contrib(xsb, ysb, dx0, dy0);
        sum += vertex_contrib(xe, ye, dxe, dye);
        q = floor_quot(sum, NORM * (64'sd1 <<< 33));
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return 16'(q);
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    // Check each result transaction against the oldest expectation
    always @(posedge i_clk) begin
        noise_result_t e;
        if (i_rst_n && o_valid && i_ready) begin
            if (noise_expected_q.size() == 0) begin
                report_mismatch("unexpected result", o_noise_value, 0);
            end else begin
                e = noise_expected_q.pop_front();
                if (o_noise_value !== e.noise)
                    report_mismatch("noise_value", o_noise_value, e.noise);
                if (o_was_build !== e.build)
                    report_mismatch("was_build", o_was_build, e.build);
            end
        end
        i_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Drive one input transaction and record what it should produce
    task automatic send_item(bit cmd, logic signed [31:0] x, logic signed [31:0] y,
                             bit known, logic signed [15:0] known_noise);
        noise_result_t e;
        if ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_command <= cmd;
        i_coord_x <= x;
        i_coord_y <= y;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        if (cmd == CMD_BUILD) begin
            shuffle_perm();
            e.noise = 16'sd0;
            e.build = 1'b1;
        end else begin
            e.noise = noise_at(x, y);
            e.build = 1'b0;
        end
        if (known) e.noise = known_noise;
        noise_expected_q.push_back(e);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (noise_expected_q.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    // Register write: setup phase, then access phase
    task automatic write_seed(logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_SEED;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        seed_q = value;
        @(posedge i_clk);
    endtask

    function automatic logic signed [31:0] pick_coord();
        case ($urandom_range(0, 3))
            0:       return $urandom;
            1:       return $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
            default: return $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
        endcase
    endfunction

    stim_row_t directed[] = '{
        '{CMD_BUILD, 32'sh0, 32'sh0, 1, 16'sd0},
        '{CMD_EVAL, 32'sh0, 32'sh0, 0, 16'sd0},
        '{CMD_EVAL, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 0, 16'sd0},
        '{CMD_EVAL, -32'sh80000000, -32'sh80000000, 0, 16'sd0},
        '{CMD_EVAL, 32'sh7FFFFFFF, -32'sh80000000, 0, 16'sd0},
        '{CMD_EVAL, -32'sh80000000, 32'sh7FFFFFFF, 0, 16'sd0},
        '{CMD_EVAL, 32'sh00010000, 32'sh0, 0, 16'sd0},
        '{CMD_EVAL, 32'sh0, 32'sh00010000, 0, 16'sd0},
        '{CMD_EVAL, 32'sh00008000, 32'sh00004000, 0, 16'sd0},
        '{CMD_EVAL, 32'sh00004000, 32'sh00008000, 0, 16'sd0},
        '{CMD_EVAL, 32'sh00008000, 32'sh00008000, 0, 16'sd0},
        '{CMD_EVAL, -32'sh00010000, -32'sh00010000, 0, 16'sd0},
        '{CMD_EVAL, 32'sh00018000, 32'sh00004000, 0, 16'sd0},
        '{CMD_EVAL, 32'sh0000C000, 32'sh0000E000, 0, 16'sd0},
        '{CMD_EVAL, 32'sh7FFF0000, 32'sh00012345, 0, 16'sd0},
        '{CMD_EVAL, -32'sh0003A000, 32'sh00025000, 0, 16'sd0},
        '{CMD_BUILD, 32'shFFFFFFFF, 32'shFFFFFFFF, 1, 16'sd0},
        '{CMD_EVAL, 32'sh00030000, -32'sh00020000, 0, 16'sd0},
        '{CMD_EVAL, 32'sh00001234, 32'sh0000ABCD, 0, 16'sd0},
        '{CMD_EVAL, 32'sh55555555, 32'shAAAAAAAA, 0, 16'sd0}
    };

    initial begin
        int idle_sel [4];
        int stall_sel[4];
        logic [31:0] seeds[4];
        idle_sel  = '{0, 72, 0, 31};
        stall_sel = '{0, 0, 72, 31};
        err_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        seed_q = '0;
        lcg_q = '0;
        for (int i = 0; i < PERM_ENTRIES; i++) begin
            perm_mem[i] = '0;
            shuf_mem[i] = '0;
        end
        seeds = '{32'h0, 32'hFFFFFFFF, $urandom, 32'h80000001};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int ph = 0; ph < 4; ph++) begin
            drain_results();
            send_idle_pct  = idle_sel[ph];
            recv_stall_pct = stall_sel[ph];
            write_seed(seeds[ph]);
            if (ph == 0) begin
                foreach (directed[k])
                    send_item(directed[k].cmd, directed[k].x, directed[k].y,
                              directed[k].known, directed[k].noise);
            end else begin
                send_item(CMD_BUILD, $urandom, $urandom, 1, 16'sd0);
            end
            // Mostly evaluations; an occasional rebuild from the same seed
            for (int n = 0; n < 380; n++) begin
                if ($urandom_range(0, 59) == 0)
                    send_item(CMD_BUILD, $urandom, $urandom, 0, 16'sd0);
                else
                    send_item(CMD_EVAL, pick_coord(), pick_coord(), 0, 16'sd0);
            end
        end
        drain_results();

        if (noise_expected_q.size() != 0)
            report_mismatch("results left over", noise_expected_q.size(), 0);
        if (err_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Hold a generous ceiling on the run time
    initial begin
        #(64'd20 * 64'd5_000_000);
        $display("Verification failed");
        $finish;
    end

endmodule

### filelist.f
rtl/core/osn_pkg.sv
rtl/core/osn_datapath.sv
rtl/core/osn_ctrl.sv
rtl/core/opensimplex_noise_2d.sv
verif/opensimplex_noise_2d_tb.sv
